FILE: rtl/core/lfb_pkg.sv
// ----------------------------------------------------------------------------
// lfb_pkg
// Types and constants shared by the LED driver frame builder.
// ----------------------------------------------------------------------------
package lfb_pkg;

  localparam int GREY_W   = 16;
  localparam int BRIGHT_W = 7;
  localparam int ROW_W    = 3 * GREY_W;
  localparam int ROWS     = 8;
  localparam int ROW_AW   = 3;
  localparam int PADDR_W  = 4;

  localparam logic [5:0] CMD_WRITE = 6'b100101;
  localparam logic [4:0] FUNC_BITS = 5'b10110;
  localparam logic [7:0] POS_MAX   = 8'd7;
  localparam logic [7:0] POS_SPLIT = 8'd4;

  localparam logic [1:0] REG_BRIGHT_RED   = 2'd0;
  localparam logic [1:0] REG_BRIGHT_GREEN = 2'd1;
  localparam logic [1:0] REG_BRIGHT_BLUE  = 2'd2;

  localparam logic REQ_SET  = 1'b0;
  localparam logic REQ_SHOW = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [7:0]        led_pos;
    logic [GREY_W-1:0] red;
    logic [GREY_W-1:0] green;
    logic [GREY_W-1:0] blue;
  } lfb_item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } lfb_result_t;

endpackage

FILE: rtl/core/lfb_ram.sv
// ----------------------------------------------------------------------------
// lfb_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lfb_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/led_driver_frame_builder.sv
// ----------------------------------------------------------------------------
// led_driver_frame_builder
// Greyscale store and serial frame builder for two chained LED drivers.
// ----------------------------------------------------------------------------
// A set request is written to the store in the cycle it is accepted; busy stays low.
// A show request keeps busy high through the frame bytes, as the result port
// carries one byte per beat; on acceptance the state moves to show, and each byte
// is then registered onto the result port together with its strobe.
// Synchronous reset clears the brightness registers and marks every store row as
// zero, so the store needs no clearing pass.
module led_driver_frame_builder
  import lfb_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  lfb_item_t           item,
  output logic                result_strobe,
  output lfb_result_t         result,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SHOW = 2'b10
  } state_t;

  state_t state;

  logic [BRIGHT_W-1:0] bright_red;
  logic [BRIGHT_W-1:0] bright_green;
  logic [BRIGHT_W-1:0] bright_blue;

  logic       drv, drv_next;
  logic       hdr, hdr_next;
  logic [1:0] hb, hb_next;
  logic [1:0] r, r_next;
  logic [2:0] b, b_next;
  logic       frame_end;

  logic [ROWS-1:0]     row_valid;
  logic                rd_valid;
  logic [ROW_AW-1:0]   rd_addr;
  logic [ROW_W-1:0]    rd_data;
  logic [ROW_W-1:0]    row;
  logic                wr_en;
  logic [ROW_AW-1:0]   wr_addr;
  logic [7:0]          pos;
  logic [31:0]         hdr_word;
  logic [7:0]          byte_out;
  logic                accept;
  logic                cfg_write;

  assign pready    = 1'b1;
  assign busy      = (state == ST_SHOW);
  assign accept    = start && !busy;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      bright_red   <= '0;
      bright_green <= '0;
      bright_blue  <= '0;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_BRIGHT_RED:   bright_red   <= pwdata[BRIGHT_W-1:0];
        REG_BRIGHT_GREEN: bright_green <= pwdata[BRIGHT_W-1:0];
        REG_BRIGHT_BLUE:  bright_blue  <= pwdata[BRIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_BRIGHT_RED:   prdata = {25'd0, bright_red};
      REG_BRIGHT_GREEN: prdata = {25'd0, bright_green};
      REG_BRIGHT_BLUE:  prdata = {25'd0, bright_blue};
      default:          prdata = '0;
    endcase
  end

  // Rows 0-3 hold channels 0-3 of the first driver, rows 4-7 those of the second.
  assign pos   = (item.led_pos > POS_MAX) ? POS_MAX : item.led_pos;
  assign wr_en = accept && (item.req_type == REQ_SET) && (pos != 8'd0);

  always_comb begin
    if (pos <= POS_SPLIT) begin
      wr_addr = ROW_AW'(pos + 8'd3);
    end else begin
      wr_addr = ROW_AW'(pos - 8'd5);
    end
  end

  always_comb begin
    drv_next  = drv;
    hdr_next  = hdr;
    hb_next   = hb;
    r_next    = r;
    b_next    = b;
    frame_end = 1'b0;
    if (hdr) begin
      if (hb == 2'd3) begin
        hdr_next = 1'b0;
        r_next   = '0;
        b_next   = '0;
      end else begin
        hb_next = hb + 2'd1;
      end
    end else if (b == 3'd5) begin
      b_next = '0;
      if (r == 2'd3) begin
        if (drv) begin
          frame_end = 1'b1;
        end else begin
          drv_next = 1'b1;
          hdr_next = 1'b1;
          hb_next  = '0;
        end
      end else begin
        r_next = r + 2'd1;
      end
    end else begin
      b_next = b + 3'd1;
    end
  end

  // The next byte's row is fetched ahead via r_next; r counts up, channels down.
  assign rd_addr = {drv_next, 2'd3 - r_next};

  lfb_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ROWS)
  ) u_grey_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata ({item.blue, item.green, item.red}),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      rd_valid <= row_valid[rd_addr];
    end
  end

  assign row      = rd_valid ? rd_data : '0;
  assign hdr_word = {CMD_WRITE, FUNC_BITS, bright_blue, bright_green, bright_red};

  always_comb begin
    if (hdr) begin
      case (hb)
        2'd0:    byte_out = hdr_word[31:24];
        2'd1:    byte_out = hdr_word[23:16];
        2'd2:    byte_out = hdr_word[15:8];
        default: byte_out = hdr_word[7:0];
      endcase
    end else begin
      case (b)
        3'd0:    byte_out = row[47:40];
        3'd1:    byte_out = row[39:32];
        3'd2:    byte_out = row[31:24];
        3'd3:    byte_out = row[23:16];
        3'd4:    byte_out = row[15:8];
        default: byte_out = row[7:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      result_strobe <= 1'b0;
      drv           <= 1'b0;
      hdr           <= 1'b1;
      hb            <= '0;
      r             <= '0;
      b             <= '0;
    end else begin
      result_strobe <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept && (item.req_type == REQ_SHOW)) begin
            state <= ST_SHOW;
            drv   <= 1'b0;
            hdr   <= 1'b1;
            hb    <= '0;
            r     <= '0;
            b     <= '0;
          end
        end
        ST_SHOW: begin
          result_strobe <= 1'b1;
          drv           <= drv_next;
          hdr           <= hdr_next;
          hb            <= hb_next;
          r             <= r_next;
          b             <= b_next;
          if (frame_end) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    result.frame_byte <= byte_out;
    result.last_byte  <= frame_end;
  end

  a_strobe_from_show: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> $past(state == ST_SHOW))
    else $error("result beat without a frame in progress");

  a_last_ends_frame: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && result.last_byte) |-> !busy)
    else $error("frame still running after its last beat");

  a_busy_from_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("frame started without a request");

  a_no_write_while_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !wr_en)
    else $error("store written during a frame");

endmodule

FILE: tb/tb_led_driver_frame_builder.sv
// ----------------------------------------------------------------------------
// tb_led_driver_frame_builder
// Self-checking bench for the LED driver frame builder.
// ----------------------------------------------------------------------------
// A directed table covers reset state, position zero, saturation, both
// brightness extremes and the unused register index. Random set and show
// requests follow, in phases separated by brightness changes. A local model
// of the greyscale store predicts untyped frames; beats are checked in order.
// ----------------------------------------------------------------------------
module tb_led_driver_frame_builder
  import lfb_pkg::*;
;

  localparam int FRAME_BYTES = 56;
  localparam int PHASES = 6;
  localparam int ITEMS_PER_PHASE = 55;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam logic [447:0] FRAME_AFTER_RESET =
    {32'h96C0_0000, 192'd0, 32'h96C0_0000, 192'd0};
  localparam logic [447:0] FRAME_ALL_ON =
    {32'h96DF_FFFF, 48'd0, {144{1'b1}}, 32'h96DF_FFFF, {192{1'b1}}};

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t    kind;
    lfb_item_t    req;
    logic [1:0]   reg_idx;
    logic [31:0]  wdata;
    bit           typed;
    logic [447:0] frame;
  } stim_row_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  lfb_item_t          item;
  logic               result_strobe;
  lfb_result_t        result;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  logic [GREY_W-1:0]   grey_words [24];
  logic [BRIGHT_W-1:0] shadow_red;
  logic [BRIGHT_W-1:0] shadow_green;
  logic [BRIGHT_W-1:0] shadow_blue;
  lfb_result_t         pending_beats [$];
  stim_row_t           stim_rows [$];
  int                  mismatches;
  int                  burst_left;

  led_driver_frame_builder u_top (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .item          (item),
    .result_strobe (result_strobe),
    .result        (result),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  function automatic logic [447:0] predict_frame();
    logic [223:0] part;
    logic [447:0] frame;
    frame = '0;
    for (int d = 0; d < 2; d++) begin
      part = {192'd0, CMD_WRITE, FUNC_BITS, shadow_blue, shadow_green, shadow_red};
      for (int ch = 3; ch >= 0; ch--) begin
        for (int col = 0; col < 3; col++) begin
          part = {part[207:0], grey_words[d*12 + ch*3 + col]};
        end
      end
      frame = {frame[223:0], part};
    end
    return frame;
  endfunction

  function automatic void store_colour(input lfb_item_t req);
    logic [7:0] pos;
    int base;
    pos = (req.led_pos > POS_MAX) ? POS_MAX : req.led_pos;
    if (pos != 8'd0) begin
      if (pos <= POS_SPLIT) base = 12 + (int'(pos) - 1) * 3;
      else base = (int'(pos) - 5) * 3;
      grey_words[base]     = req.blue;
      grey_words[base + 1] = req.green;
      grey_words[base + 2] = req.red;
    end
  endfunction

  function automatic void add_item(input logic req_type, input logic [7:0] pos,
                                   input logic [15:0] r, input logic [15:0] g,
                                   input logic [15:0] b, input bit typed,
                                   input logic [447:0] frame);
    stim_row_t row;
    row.kind    = ROW_ITEM;
    row.req     = '{req_type, pos, r, g, b};
    row.reg_idx = '0;
    row.wdata   = '0;
    row.typed   = typed;
    row.frame   = frame;
    stim_rows.push_back(row);
  endfunction

  function automatic void add_cfg(input logic [1:0] idx, input logic [31:0] data);
    stim_row_t row;
    row.kind    = ROW_CFG;
    row.req     = '0;
    row.reg_idx = idx;
    row.wdata   = data;
    row.typed   = 1'b0;
    row.frame   = '0;
    stim_rows.push_back(row);
  endfunction

  function automatic logic [15:0] rand_grey();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_item(input lfb_item_t req, input bit typed,
                           input logic [447:0] typed_frame);
    int gap;
    logic [447:0] frame;
    lfb_result_t beat;
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else begin
      gap = $urandom_range(0, 8);
      if ($urandom_range(0, 15) == 0) burst_left = $urandom_range(5, 20);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item  <= req;
    do @(posedge clk); while (busy);
    if (req.req_type == REQ_SET) begin
      store_colour(req);
    end else begin
      frame = typed ? typed_frame : predict_frame();
      for (int k = 0; k < FRAME_BYTES; k++) begin
        beat.frame_byte = frame[447 - 8*k -: 8];
        beat.last_byte  = (k == FRAME_BYTES - 1);
        pending_beats.push_back(beat);
      end
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending_beats.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_transfer(input bit wr, input logic [1:0] idx,
                              input logic [31:0] data, output logic [31:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
  endtask

  task automatic config_write(input logic [1:0] idx, input logic [31:0] data);
    logic [31:0] rd;
    logic [BRIGHT_W-1:0] want;
    apb_transfer(1'b1, idx, data, rd);
    case (idx)
      REG_BRIGHT_RED:   shadow_red   = data[BRIGHT_W-1:0];
      REG_BRIGHT_GREEN: shadow_green = data[BRIGHT_W-1:0];
      REG_BRIGHT_BLUE:  shadow_blue  = data[BRIGHT_W-1:0];
      default: ;
    endcase
    if (idx != REG_UNUSED) begin
      apb_transfer(1'b0, idx, 32'd0, rd);
      case (idx)
        REG_BRIGHT_RED:   want = shadow_red;
        REG_BRIGHT_GREEN: want = shadow_green;
        default:          want = shadow_blue;
      endcase
      if (rd !== {25'd0, want}) report_mismatch("register readback", rd, {25'd0, want});
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    lfb_result_t want;
    if (!rst && result_strobe) begin
      if (pending_beats.size() == 0) begin
        report_mismatch("frame beat with nothing pending", 32'(result), 32'd0);
      end else begin
        want = pending_beats.pop_front();
        if (result.frame_byte !== want.frame_byte)
          report_mismatch("frame_byte", 32'(result.frame_byte), 32'(want.frame_byte));
        if (result.last_byte !== want.last_byte)
          report_mismatch("last_byte", 32'(result.last_byte), 32'(want.last_byte));
      end
    end
  end

  initial begin
    lfb_item_t   req;
    logic [1:0]  bright_regs [3];
    logic [31:0] wdata;
    int          v;

    bright_regs  = '{REG_BRIGHT_RED, REG_BRIGHT_GREEN, REG_BRIGHT_BLUE};
    mismatches   = 0;
    burst_left   = 0;
    shadow_red   = '0;
    shadow_green = '0;
    shadow_blue  = '0;
    foreach (grey_words[i]) grey_words[i] = '0;
    rst     = 1'b1;
    start   = 1'b0;
    item    = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;

    add_item(REQ_SHOW, 8'd0, 16'd0, 16'd0, 16'd0, 1'b1, FRAME_AFTER_RESET);
    add_item(REQ_SET, 8'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, '0);
    add_item(REQ_SHOW, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, FRAME_AFTER_RESET);
    add_cfg(REG_BRIGHT_RED, 32'hFFFF_FFFF);
    add_cfg(REG_BRIGHT_GREEN, 32'h0000_007F);
    add_cfg(REG_BRIGHT_BLUE, 32'h8000_007F);
    add_cfg(REG_UNUSED, 32'd0);
    for (int p = 1; p <= 6; p++)
      add_item(REQ_SET, 8'(p), 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, '0);
    add_item(REQ_SET, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, '0);
    add_item(REQ_SHOW, 8'd0, 16'd0, 16'd0, 16'd0, 1'b1, FRAME_ALL_ON);
    add_item(REQ_SET, 8'd8, 16'h1234, 16'h5678, 16'h9ABC, 1'b0, '0);
    add_item(REQ_SET, 8'd1, 16'h0001, 16'h8000, 16'h00FF, 1'b0, '0);
    add_item(REQ_SET, 8'd4, 16'hA5A5, 16'h5A5A, 16'h0F0F, 1'b0, '0);
    add_cfg(REG_BRIGHT_RED, 32'd0);
    add_cfg(REG_BRIGHT_GREEN, 32'h0000_0055);
    add_cfg(REG_BRIGHT_BLUE, 32'h0000_002A);
    add_item(REQ_SHOW, 8'd3, 16'h1111, 16'h2222, 16'h3333, 1'b0, '0);
    add_item(REQ_SET, 8'd5, 16'd0, 16'd0, 16'd0, 1'b0, '0);
    add_item(REQ_SHOW, 8'd0, 16'd0, 16'd0, 16'd0, 1'b0, '0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_CFG) begin
        wait_idle();
        config_write(stim_rows[i].reg_idx, stim_rows[i].wdata);
      end else begin
        send_item(stim_rows[i].req, stim_rows[i].typed, stim_rows[i].frame);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      foreach (bright_regs[r]) begin
        case ($urandom_range(0, 2))
          0: v = 0;
          1: v = 127;
          default: v = $urandom_range(0, 127);
        endcase
        wdata = ($urandom_range(0, 1) ? ($urandom & 32'hFFFF_FF80) : 32'd0) | v;
        config_write(bright_regs[r], wdata);
      end
      if ($urandom_range(0, 1)) config_write(REG_UNUSED, $urandom);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        req.req_type = ($urandom_range(0, 3) == 0) ? REQ_SHOW : REQ_SET;
        req.led_pos  = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                   : 8'($urandom_range(0, 7));
        req.red      = rand_grey();
        req.green    = rand_grey();
        req.blue     = rand_grey();
        send_item(req, 1'b0, '0);
      end
    end

    start <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
